// File: src/histogram_mode_finder_assert.svh
`ifndef HISTOGRAM_MODE_FINDER_ASSERT_SVH
`define HISTOGRAM_MODE_FINDER_ASSERT_SVH

// Same-cycle implication, checked on i_clk and held off while i_rst_n is low.
`define HMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk and held off while i_rst_n is low.
`define HMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/hmf_pkg.sv
`default_nettype none

package hmf_pkg;

    localparam int BIN_COUNT   = 16384;
    localparam int COUNT_BITS  = 16;
    localparam int ADDR_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int VALUE_W     = 14;
    localparam int OUT_COUNT_W = 16;

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [VALUE_W-1:0]     t_value;
    typedef logic [OUT_COUNT_W-1:0] t_out_count;

    localparam t_count COUNT_MAX = '1;
    localparam t_addr  LAST_ADDR = t_addr'(BIN_COUNT - 1);

    // Control from the sequencer to the running-maximum unit.
    typedef struct packed {
        logic clear;
        logic update;
    } t_best_ctl;

    // Counters wider than the result field saturate at the field maximum.
    function automatic t_out_count sat_out(input t_count c);
        logic [31:0] w;
        begin
            w = 32'(c);
            if (w > 32'(t_out_count'('1))) begin
                return '1;
            end
            return t_out_count'(w);
        end
    endfunction

endpackage

`default_nettype wire

// File: src/hmf_ram.sv
`default_nettype none

module hmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                  i_wdata,
    input  wire logic                              i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/hmf_best.sv
`default_nettype none

module hmf_best (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hmf_pkg::t_best_ctl i_ctl,
    input  wire hmf_pkg::t_count    i_count,
    input  wire hmf_pkg::t_addr     i_index,
    output hmf_pkg::t_count         o_best_count,
    output hmf_pkg::t_addr          o_best_index
);

    import hmf_pkg::*;

    `include "histogram_mode_finder_assert.svh"

    t_count r_best_count;
    t_addr  r_best_index;
    logic   w_better;

    // Strictly greater keeps the smallest index on ties, since bins arrive in order.
    assign w_better = i_count > r_best_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_best_count <= '0;
            r_best_index <= '0;
        end else if (i_ctl.update && w_better) begin
            r_best_count <= i_count;
            r_best_index <= i_index;
        end
    end

    assign o_best_count = r_best_count;
    assign o_best_index = r_best_index;

    `HMF_ASSERT_NEXT(a_best_clear, i_ctl.clear,
        (r_best_count == '0) && (r_best_index == '0), "best not cleared")
    `HMF_ASSERT_NEXT(a_best_take, !i_ctl.clear && i_ctl.update && w_better,
        (r_best_index == $past(i_index)) && (r_best_count == $past(i_count)),
        "larger count not taken")
    `HMF_ASSERT_NEXT(a_best_keep, !i_ctl.clear && i_ctl.update && !w_better,
        $stable(r_best_count) && $stable(r_best_index), "tie or smaller count replaced best")

endmodule

`default_nettype wire

// File: src/histogram_mode_finder.sv
// Each non-final sample is read from its bin, then written back with a saturating increment.
// A final sample adds a scan of every bin through the single memory read port:
// the result reaches the output register through the COUNT, SCAN, DRAIN and FINISH states.
// A new sample is taken only in ST_IDLE, so none is accepted before the last one is done.
// After reset a clearing pass writes zero to all BIN_COUNT bins,
// and the scan clears each bin behind it; o_stall stays high during both.
`default_nettype none

module histogram_mode_finder (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire hmf_pkg::t_value i_sample_value,
    input  wire logic            i_last_sample,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output hmf_pkg::t_value      o_mode_value,
    output hmf_pkg::t_out_count  o_mode_count
);

    import hmf_pkg::*;

    `include "histogram_mode_finder_assert.svh"

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_COUNT  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    t_addr      r_idx, n_idx;
    t_addr      r_addr;
    logic       r_in_range;
    logic       r_last;
    logic       r_rd_vld;
    t_addr      r_rd_addr;
    logic       r_out_valid;
    t_value     r_mode_value;
    t_out_count r_mode_count;

    logic       w_accept;
    logic       w_range;
    logic       w_we;
    t_addr      w_waddr;
    t_count     w_wdata;
    logic       w_re;
    t_addr      w_raddr;
    t_count     w_rdata;
    t_best_ctl  w_best_ctl;
    t_count     w_best_count;
    t_addr      w_best_index;
    logic       w_out_free;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_range  = {3'b000, i_sample_value} < 17'(BIN_COUNT);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_we    = 1'b0;
        w_waddr = r_rd_addr;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = t_addr'(i_sample_value);
        w_best_ctl = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                n_idx   = r_idx + t_addr'(1);
                if (r_idx == LAST_ADDR) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_re = w_accept;
                if (w_accept) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                w_we    = r_in_range;
                w_waddr = r_addr;
                w_wdata = (w_rdata == COUNT_MAX) ? w_rdata : w_rdata + t_count'(1);
                if (r_last) begin
                    w_best_ctl.clear = 1'b1;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                w_re    = 1'b1;
                w_raddr = r_idx;
                n_idx   = r_idx + t_addr'(1);
                // The bin read in the previous cycle is judged and cleared behind the read.
                w_we    = r_rd_vld;
                w_best_ctl.update = r_rd_vld;
                if (r_idx == LAST_ADDR) begin
                    n_idx   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                w_we    = 1'b1;
                w_best_ctl.update = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= (r_state == ST_SCAN);
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr     <= t_addr'(i_sample_value);
            r_in_range <= w_range;
            r_last     <= i_last_sample;
        end
        r_rd_addr <= r_idx;
        if (r_state == ST_FINISH && w_out_free) begin
            r_mode_value <= t_value'(w_best_index);
            r_mode_count <= sat_out(w_best_count);
        end
    end

    hmf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hmf_best u_best (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_best_ctl),
        .i_count      (w_rdata),
        .i_index      (r_rd_addr),
        .o_best_count (w_best_count),
        .o_best_index (w_best_index)
    );

    assign o_valid      = r_out_valid;
    assign o_mode_value = r_mode_value;
    assign o_mode_count = r_mode_count;

    `HMF_ASSERT_NEXT(a_accept_counts, w_accept, r_state == ST_COUNT,
        "transfer did not start a count")
    `HMF_ASSERT_NOW(a_drain_has_data, r_state == ST_DRAIN, r_rd_vld,
        "drain without a pending bin read")
    `HMF_ASSERT_NOW(a_no_port_clash, w_we && w_re, w_waddr != w_raddr,
        "bin memory read and write at the same address")

endmodule

`default_nettype wire
